// ===== sv/ufx_pkg.sv =====
// Package for the UART ring buffer block with software flow control.
// Holds ring sizes, flow codes, operation codes, shared structs and helper functions.
// No dependencies.
`default_nettype none

package ufx_pkg;

   // Ring sizes and the widths that follow from them.
   localparam int RX_DEPTH = 128;
   localparam int TX_DEPTH = 32;
   localparam int RX_PTR_W = $clog2(RX_DEPTH);
   localparam int TX_PTR_W = $clog2(TX_DEPTH);
   // Fill width wide enough to compare against the 7-bit levels.
   localparam int RX_FW = (RX_PTR_W > 7) ? RX_PTR_W : 7;

   // Flow control characters.
   localparam logic [7:0] XON_BYTE  = 8'd17;
   localparam logic [7:0] XOFF_BYTE = 8'd19;

   // Operation codes of an input item.
   localparam logic [2:0] FUNC_RX       = 3'd0;
   localparam logic [2:0] FUNC_READ     = 3'd1;
   localparam logic [2:0] FUNC_PEEK     = 3'd2;
   localparam logic [2:0] FUNC_FLUSH    = 3'd3;
   localparam logic [2:0] FUNC_WRITE    = 3'd4;
   localparam logic [2:0] FUNC_TX_READY = 3'd5;

   // Configuration register indexes.
   localparam logic [1:0] CSR_FLOW_ENABLE = 2'd0;
   localparam logic [1:0] CSR_XOFF_LEVEL  = 2'd1;
   localparam logic [1:0] CSR_XON_LEVEL   = 2'd2;

   // Last flow character sent or pending.
   typedef enum logic [2:0] {
      FLOW_XON_SENT    = 3'b001,
      FLOW_XOFF_SENT   = 3'b010,
      FLOW_XON_PENDING = 3'b100
   } flow_type;

   // One result item.
   typedef struct packed {
      logic       read_valid;
      logic [7:0] read_byte;
      logic       write_accepted;
      logic       send_valid;
      logic [7:0] send_byte;
      logic [6:0] rx_queued;
      logic       tx_pending;
      logic       tx_empty;
      logic [7:0] dropped_count;
      logic [7:0] overrun_count;
      logic [7:0] framing_count;
      logic [6:0] max_queued;
   } rsp_type;

   // Write requests to the two ring memories.
   typedef struct packed {
      logic                en;
      logic [RX_PTR_W-1:0] addr;
      logic [7:0]          data;
   } rx_wr_type;

   typedef struct packed {
      logic                en;
      logic [TX_PTR_W-1:0] addr;
      logic [7:0]          data;
   } tx_wr_type;

   // Pointer advance with wrap at the ring depth.
   function automatic logic [RX_PTR_W-1:0] rx_next(input logic [RX_PTR_W-1:0] p);
      return (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [TX_PTR_W-1:0] tx_next(input logic [TX_PTR_W-1:0] p);
      return (p == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Receive fill, extended to the compare width.
   function automatic logic [RX_FW-1:0] rx_fill(input logic [RX_PTR_W-1:0] head,
                                                input logic [RX_PTR_W-1:0] tail);
      logic [RX_PTR_W-1:0] diff;
      diff = head - tail;
      if (head < tail) begin
         diff = diff + RX_PTR_W'(RX_DEPTH);
      end
      return RX_FW'(diff);
   endfunction

   // Clamp a fill to the 7-bit status fields.
   function automatic logic [6:0] sat7(input logic [RX_FW-1:0] v);
      return (v > RX_FW'(127)) ? 7'd127 : v[6:0];
   endfunction

   // Counter increment that sticks at its maximum.
   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
   endfunction

endpackage

`default_nettype wire

// ===== sv/ufx_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for both byte rings; no package dependency.
`default_nettype none

module ufx_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read port with registered read data, enabled by re.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/ufx_engine.sv =====
// Ring pointers, flow control state, statistics and configuration registers.
// Computes one result from the registered item and the memory read data.
// Depends on ufx_pkg.
`default_nettype none

module ufx_engine (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         commit,
   input  wire logic [2:0]                   func,
   input  wire logic [7:0]                   data,
   input  wire logic                         overrun_flag,
   input  wire logic                         framing_flag,
   input  wire logic [7:0]                   rx_rdata,
   input  wire logic [7:0]                   tx_rdata,
   input  wire logic                         csr_write_enable,
   input  wire logic [1:0]                   csr_index,
   input  wire logic [6:0]                   csr_wdata,
   output logic      [ufx_pkg::RX_PTR_W-1:0] rx_raddr,
   output logic      [ufx_pkg::TX_PTR_W-1:0] tx_raddr,
   output ufx_pkg::rx_wr_type                rx_wr,
   output ufx_pkg::tx_wr_type                tx_wr,
   output ufx_pkg::rsp_type                  result
);

   logic [ufx_pkg::RX_PTR_W-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [ufx_pkg::TX_PTR_W-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [ufx_pkg::RX_PTR_W-1:0] rx_nx;
   logic [ufx_pkg::TX_PTR_W-1:0] tx_nx;
   ufx_pkg::flow_type            flow_ff, flow_in;
   logic [7:0]                   drop_ff, drop_in, ovr_ff, ovr_in, frm_ff, frm_in;
   logic [ufx_pkg::RX_FW-1:0]    peak_ff, peak_in, fill;
   logic                         flow_enable_ff;
   logic [6:0]                   xoff_level_ff, xon_level_ff;
   logic                         rx_we, tx_we;

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         flow_enable_ff <= 1'b1;
         xoff_level_ff  <= 7'd16;
         xon_level_ff   <= 7'd12;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ufx_pkg::CSR_FLOW_ENABLE: flow_enable_ff <= csr_wdata[0];
            ufx_pkg::CSR_XOFF_LEVEL:  xoff_level_ff  <= csr_wdata;
            ufx_pkg::CSR_XON_LEVEL:   xon_level_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next state and result for the item in execution.
   always_comb begin
      rx_head_in = rx_head_ff;
      rx_tail_in = rx_tail_ff;
      tx_head_in = tx_head_ff;
      tx_tail_in = tx_tail_ff;
      flow_in    = flow_ff;
      drop_in    = drop_ff;
      ovr_in     = ovr_ff;
      frm_in     = frm_ff;
      peak_in    = peak_ff;
      rx_we      = 1'b0;
      tx_we      = 1'b0;
      rx_nx      = ufx_pkg::rx_next(rx_head_ff);
      tx_nx      = ufx_pkg::tx_next(tx_head_ff);
      fill       = '0;
      result     = '0;

      unique case (func)
         ufx_pkg::FUNC_RX: begin
            if (overrun_flag) begin
               drop_in = ufx_pkg::sat_inc(drop_in);
               ovr_in  = ufx_pkg::sat_inc(ovr_ff);
            end
            if (framing_flag) begin
               frm_in = ufx_pkg::sat_inc(frm_ff);
            end
            if (rx_nx != rx_tail_ff) begin
               rx_we      = 1'b1;
               rx_head_in = rx_nx;
            end else begin
               drop_in = ufx_pkg::sat_inc(drop_in);
            end
            fill = ufx_pkg::rx_fill(rx_head_in, rx_tail_ff);
            if (fill > peak_ff) begin
               peak_in = fill;
            end
            if (flow_enable_ff && flow_ff != ufx_pkg::FLOW_XOFF_SENT &&
                fill >= ufx_pkg::RX_FW'(xoff_level_ff)) begin
               flow_in           = ufx_pkg::FLOW_XOFF_SENT;
               result.send_valid = 1'b1;
               result.send_byte  = ufx_pkg::XOFF_BYTE;
            end
         end
         ufx_pkg::FUNC_READ, ufx_pkg::FUNC_PEEK: begin
            if (rx_head_ff != rx_tail_ff) begin
               result.read_valid = 1'b1;
               result.read_byte  = rx_rdata;
               if (func == ufx_pkg::FUNC_READ) begin
                  rx_tail_in = ufx_pkg::rx_next(rx_tail_ff);
                  fill       = ufx_pkg::rx_fill(rx_head_ff, rx_tail_in);
                  if (flow_enable_ff && flow_ff == ufx_pkg::FLOW_XOFF_SENT &&
                      fill < ufx_pkg::RX_FW'(xon_level_ff)) begin
                     flow_in = ufx_pkg::FLOW_XON_PENDING;
                  end
               end
            end
         end
         ufx_pkg::FUNC_FLUSH: begin
            rx_tail_in = rx_head_ff;
            if (flow_enable_ff && flow_ff == ufx_pkg::FLOW_XOFF_SENT) begin
               flow_in = ufx_pkg::FLOW_XON_PENDING;
            end
         end
         ufx_pkg::FUNC_WRITE: begin
            if (tx_nx != tx_tail_ff) begin
               tx_we                 = 1'b1;
               tx_head_in            = tx_nx;
               result.write_accepted = 1'b1;
            end
         end
         ufx_pkg::FUNC_TX_READY: begin
            if (flow_ff == ufx_pkg::FLOW_XON_PENDING) begin
               flow_in           = ufx_pkg::FLOW_XON_SENT;
               result.send_valid = 1'b1;
               result.send_byte  = ufx_pkg::XON_BYTE;
            end else if (tx_head_ff != tx_tail_ff) begin
               result.send_valid = 1'b1;
               result.send_byte  = tx_rdata;
               tx_tail_in        = ufx_pkg::tx_next(tx_tail_ff);
            end
         end
         default: ;
      endcase

      // Status after the step.
      result.rx_queued     = ufx_pkg::sat7(ufx_pkg::rx_fill(rx_head_in, rx_tail_in));
      result.tx_pending    = (tx_head_in != tx_tail_in) ||
                             (flow_in == ufx_pkg::FLOW_XON_PENDING);
      result.tx_empty      = (tx_head_in == tx_tail_in);
      result.dropped_count = drop_in;
      result.overrun_count = ovr_in;
      result.framing_count = frm_in;
      result.max_queued    = ufx_pkg::sat7(peak_in);
   end

   // State update when the result is committed.
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff <= '0;
         rx_tail_ff <= '0;
         tx_head_ff <= '0;
         tx_tail_ff <= '0;
         flow_ff    <= ufx_pkg::FLOW_XON_SENT;
         drop_ff    <= '0;
         ovr_ff     <= '0;
         frm_ff     <= '0;
         peak_ff    <= '0;
      end else if (commit) begin
         rx_head_ff <= rx_head_in;
         rx_tail_ff <= rx_tail_in;
         tx_head_ff <= tx_head_in;
         tx_tail_ff <= tx_tail_in;
         flow_ff    <= flow_in;
         drop_ff    <= drop_in;
         ovr_ff     <= ovr_in;
         frm_ff     <= frm_in;
         peak_ff    <= peak_in;
      end
   end

   // Memory requests: reads look at the oldest entry, writes go to the head.
   assign rx_raddr   = rx_tail_ff;
   assign tx_raddr   = tx_tail_ff;
   assign rx_wr.en   = commit & rx_we;
   assign rx_wr.addr = rx_head_ff;
   assign rx_wr.data = data;
   assign tx_wr.en   = commit & tx_we;
   assign tx_wr.addr = tx_head_ff;
   assign tx_wr.data = data;

endmodule

`default_nettype wire

// ===== sv/uart_fifo_xon_xoff.sv =====
// Top level of the UART receive/transmit rings with XON/XOFF flow control.
// Depends on ufx_pkg, ufx_ram and ufx_engine.
//
//   Channel  Direction  Handshake                 Payload
//   req_     in         req_valid / req_stall     func, data, overrun_flag, framing_flag
//   rsp_     out        rsp_valid / rsp_stall     read/write/send status and counters
//   csr_     in         csr_write_enable          csr_index, csr_wdata
//
// For each item, the ring memories are read at the accept edge
// and the result is computed from the registered read data in the next cycle.
// The next item is accepted once that result sits in the output register.
// A stalled result holds the item in execution until the register frees up.
// Reset is synchronous; it clears the pointers, flow state, counters and registers, not the ring contents.
`default_nettype none

module uart_fifo_xon_xoff (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_func,
   input  wire logic [7:0] req_data,
   input  wire logic       req_overrun_flag,
   input  wire logic       req_framing_flag,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_read_valid,
   output logic      [7:0] rsp_read_byte,
   output logic            rsp_write_accepted,
   output logic            rsp_send_valid,
   output logic      [7:0] rsp_send_byte,
   output logic      [6:0] rsp_rx_queued,
   output logic            rsp_tx_pending,
   output logic            rsp_tx_empty,
   output logic      [7:0] rsp_dropped_count,
   output logic      [7:0] rsp_overrun_count,
   output logic      [7:0] rsp_framing_count,
   output logic      [6:0] rsp_max_queued,
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_index,
   input  wire logic [6:0] csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type                    state_ff, state_in;
   logic [2:0]                   func_ff;
   logic [7:0]                   data_ff;
   logic                         ovr_ff, frm_ff;
   logic                         req_accept, commit;
   logic                         rsp_valid_ff;
   ufx_pkg::rsp_type             rsp_ff, result;
   ufx_pkg::rx_wr_type           rx_wr;
   ufx_pkg::tx_wr_type           tx_wr;
   logic [ufx_pkg::RX_PTR_W-1:0] rx_raddr;
   logic [ufx_pkg::TX_PTR_W-1:0] tx_raddr;
   logic [7:0]                   rx_rdata, tx_rdata;

   // Input transfer and result commit.
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign commit     = (state_ff == S_EXEC) & (~rsp_valid_ff | ~rsp_stall);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_EXEC;
         S_EXEC: if (commit) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Item register.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff <= req_func;
         data_ff <= req_data;
         ovr_ff  <= req_overrun_flag;
         frm_ff  <= req_framing_flag;
      end
   end

   // Ring memories.
   ufx_ram #(.DEPTH(ufx_pkg::RX_DEPTH), .WIDTH(8)) u_rx_ram (
      .clock (clock),
      .we    (rx_wr.en),
      .waddr (rx_wr.addr),
      .wdata (rx_wr.data),
      .re    (req_accept),
      .raddr (rx_raddr),
      .rdata (rx_rdata)
   );

   ufx_ram #(.DEPTH(ufx_pkg::TX_DEPTH), .WIDTH(8)) u_tx_ram (
      .clock (clock),
      .we    (tx_wr.en),
      .waddr (tx_wr.addr),
      .wdata (tx_wr.data),
      .re    (req_accept),
      .raddr (tx_raddr),
      .rdata (tx_rdata)
   );

   ufx_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .commit           (commit),
      .func             (func_ff),
      .data             (data_ff),
      .overrun_flag     (ovr_ff),
      .framing_flag     (frm_ff),
      .rx_rdata         (rx_rdata),
      .tx_rdata         (tx_rdata),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rx_raddr         (rx_raddr),
      .tx_raddr         (tx_raddr),
      .rx_wr            (rx_wr),
      .tx_wr            (tx_wr),
      .result           (result)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_valid     = rsp_ff.read_valid;
   assign rsp_read_byte      = rsp_ff.read_byte;
   assign rsp_write_accepted = rsp_ff.write_accepted;
   assign rsp_send_valid     = rsp_ff.send_valid;
   assign rsp_send_byte      = rsp_ff.send_byte;
   assign rsp_rx_queued      = rsp_ff.rx_queued;
   assign rsp_tx_pending     = rsp_ff.tx_pending;
   assign rsp_tx_empty       = rsp_ff.tx_empty;
   assign rsp_dropped_count  = rsp_ff.dropped_count;
   assign rsp_overrun_count  = rsp_ff.overrun_count;
   assign rsp_framing_count  = rsp_ff.framing_count;
   assign rsp_max_queued     = rsp_ff.max_queued;

   // An accepted item is always in execution in the next cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_EXEC))
      else $error("accepted item not in execution");

   // A commit always leaves a valid result in the output register.
   a_commit_out: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("committed result not presented");

   // Ring writes only happen at a commit, never with a memory read.
   a_write_commit: assert property (@(posedge clock) disable iff (reset)
      (rx_wr.en || tx_wr.en) |-> (commit && !req_accept))
      else $error("ring write outside of commit");

   // A result never reports a read together with a stored write.
   a_excl_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.read_valid && rsp_ff.write_accepted))
      else $error("read and write reported together");

   // A nonempty transmit ring always asks for service.
   a_tx_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.tx_empty) |-> rsp_ff.tx_pending)
      else $error("queued bytes without service request");

endmodule

`default_nettype wire

// ===== dv/ufx_ring_shadow_pkg.sv =====
// Shadow model and status checker for the UART ring block with XON/XOFF flow control.
// Depends on ufx_pkg for the ring sizes, operation and register codes, flow enum and result struct.
package ufx_ring_shadow_pkg;
   import ufx_pkg::*;

   // Mismatch lines printed before the checker goes quiet; all are still counted.
   localparam int MAX_REPORTS = 100;

   class ufx_ring_shadow;
      // Status words still owed by the block, oldest first.
      rsp_type status_due[$];

      // Shadow copy of both rings, the flow state and the statistics.
      logic [7:0]          rx_ring [RX_DEPTH];
      logic [RX_PTR_W-1:0] rx_head;
      logic [RX_PTR_W-1:0] rx_tail;
      logic [7:0]          tx_ring [TX_DEPTH];
      logic [TX_PTR_W-1:0] tx_head;
      logic [TX_PTR_W-1:0] tx_tail;
      flow_type            flow;
      logic [7:0]          drops;
      logic [7:0]          overruns;
      logic [7:0]          framings;
      int                  peak;

      // Copies of the configuration registers.
      logic       flow_on;
      logic [6:0] xoff_lvl;
      logic [6:0] xon_lvl;

      // Run statistics.
      int errors;
      int events;
      int checked;
      int xoff_sent;
      int xon_sent;
      int refused;

      function new();
         rx_head   = '0;
         rx_tail   = '0;
         tx_head   = '0;
         tx_tail   = '0;
         flow      = FLOW_XON_SENT;
         drops     = '0;
         overruns  = '0;
         framings  = '0;
         peak      = 0;
         flow_on   = 1'b1;
         xoff_lvl  = 7'd16;
         xon_lvl   = 7'd12;
         errors    = 0;
         events    = 0;
         checked   = 0;
         xoff_sent = 0;
         xon_sent  = 0;
         refused   = 0;
      endfunction

      function logic [RX_PTR_W-1:0] step_rx(logic [RX_PTR_W-1:0] p);
         return (int'(p) == RX_DEPTH - 1) ? '0 : p + 1'b1;
      endfunction

      function logic [TX_PTR_W-1:0] step_tx(logic [TX_PTR_W-1:0] p);
         return (int'(p) == TX_DEPTH - 1) ? '0 : p + 1'b1;
      endfunction

      function int rx_level();
         return (int'(rx_head) + RX_DEPTH - int'(rx_tail)) % RX_DEPTH;
      endfunction

      function logic [6:0] clip7(int v);
         return (v > 127) ? 7'd127 : 7'(v);
      endfunction

      function logic [7:0] bump(logic [7:0] v);
         return (v == 8'hFF) ? v : v + 8'd1;
      endfunction

      function int pending();
         return status_due.size();
      endfunction

      // A register write lands while the block is idle, so it takes effect at once.
      function void set_reg(logic [1:0] idx, logic [6:0] val);
         case (idx)
            CSR_FLOW_ENABLE: flow_on = val[0];
            CSR_XOFF_LEVEL:  xoff_lvl = val;
            CSR_XON_LEVEL:   xon_lvl = val;
            default: ;
         endcase
      endfunction

      // Advance the shadow by one accepted transfer and queue the status it must produce.
      function void apply_event(logic [2:0] func, logic [7:0] data, logic ovr, logic frm);
         rsp_type             r;
         logic [RX_PTR_W-1:0] nx;
         logic [TX_PTR_W-1:0] tnx;
         int                  fill;
         r = '0;
         events++;
         case (func)
            FUNC_RX: begin
               nx = step_rx(rx_head);
               if (ovr) begin
                  drops = bump(drops);
                  overruns = bump(overruns);
               end
               if (frm) begin
                  framings = bump(framings);
               end
               // A full ring discards the byte; the overrun still counts on its own.
               if (nx != rx_tail) begin
                  rx_ring[rx_head] = data;
                  rx_head = nx;
               end else begin
                  drops = bump(drops);
               end
               fill = rx_level();
               if (fill > peak) begin
                  peak = fill;
               end
               if (flow_on && flow != FLOW_XOFF_SENT && fill >= int'(xoff_lvl)) begin
                  flow = FLOW_XOFF_SENT;
                  r.send_valid = 1'b1;
                  r.send_byte = XOFF_BYTE;
                  xoff_sent++;
               end
            end
            FUNC_READ, FUNC_PEEK: begin
               if (rx_head != rx_tail) begin
                  r.read_valid = 1'b1;
                  r.read_byte = rx_ring[rx_tail];
                  if (func == FUNC_READ) begin
                     rx_tail = step_rx(rx_tail);
                     if (flow_on && flow == FLOW_XOFF_SENT && rx_level() < int'(xon_lvl)) begin
                        flow = FLOW_XON_PENDING;
                     end
                  end
               end
            end
            FUNC_FLUSH: begin
               rx_tail = rx_head;
               if (flow_on && flow == FLOW_XOFF_SENT) begin
                  flow = FLOW_XON_PENDING;
               end
            end
            FUNC_WRITE: begin
               tnx = step_tx(tx_head);
               if (tnx != tx_tail) begin
                  tx_ring[tx_head] = data;
                  tx_head = tnx;
                  r.write_accepted = 1'b1;
               end else begin
                  refused++;
               end
            end
            FUNC_TX_READY: begin
               // A pending XON goes out ahead of any queued byte, flow control on or off.
               if (flow == FLOW_XON_PENDING) begin
                  flow = FLOW_XON_SENT;
                  r.send_valid = 1'b1;
                  r.send_byte = XON_BYTE;
                  xon_sent++;
               end else if (tx_head != tx_tail) begin
                  r.send_valid = 1'b1;
                  r.send_byte = tx_ring[tx_tail];
                  tx_tail = step_tx(tx_tail);
               end
            end
            default: ;
         endcase
         r.rx_queued     = clip7(rx_level());
         r.tx_pending    = (tx_head != tx_tail) || (flow == FLOW_XON_PENDING);
         r.tx_empty      = (tx_head == tx_tail);
         r.dropped_count = drops;
         r.overrun_count = overruns;
         r.framing_count = framings;
         r.max_queued    = clip7(peak);
         status_due.push_back(r);
      endfunction

      function void same(string name, logic [7:0] want, logic [7:0] seen);
         if (seen !== want) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("%0t: status %0d field %s expected %h, got %h",
                        $time, checked, name, want, seen);
            end
         end
      endfunction

      // Compare one accepted status transfer against the oldest expectation.
      function void match_status(rsp_type seen);
         rsp_type want;
         if (status_due.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("%0t: status transfer with nothing expected, expected none, got %h",
                        $time, seen);
            end
            return;
         end
         want = status_due.pop_front();
         checked++;
         same("read_valid", want.read_valid, seen.read_valid);
         same("read_byte", want.read_byte, seen.read_byte);
         same("write_accepted", want.write_accepted, seen.write_accepted);
         same("send_valid", want.send_valid, seen.send_valid);
         same("send_byte", want.send_byte, seen.send_byte);
         same("rx_queued", want.rx_queued, seen.rx_queued);
         same("tx_pending", want.tx_pending, seen.tx_pending);
         same("tx_empty", want.tx_empty, seen.tx_empty);
         same("dropped_count", want.dropped_count, seen.dropped_count);
         same("overrun_count", want.overrun_count, seen.overrun_count);
         same("framing_count", want.framing_count, seen.framing_count);
         same("max_queued", want.max_queued, seen.max_queued);
      endfunction
   endclass

endpackage

// ===== dv/uart_fifo_xon_xoff_tb.sv =====
// Top-level testbench for uart_fifo_xon_xoff: directed and random ring traffic with flow control.
// Depends on ufx_pkg, ufx_ring_shadow_pkg and the RTL of the block.
module uart_fifo_xon_xoff_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ufx_pkg::*;
   import ufx_ring_shadow_pkg::*;

   localparam int CLK_PERIOD    = 4;
   localparam int RESET_CYCLES  = 5;
   localparam int GAP_MAX       = 6;
   localparam int SETTLE_CYCLES = 6;
   localparam int NUM_PHASES    = 6;
   localparam int PHASE_ITEMS   = 300;
   localparam int CYCLE_LIMIT   = 400000;

   // Function codes the block treats as no operation.
   localparam logic [2:0] FUNC_NOP_6 = 3'd6;
   localparam logic [2:0] FUNC_NOP_7 = 3'd7;

   // Traffic shapes for one burst of random transfers.
   typedef enum int {
      MODE_RX_FILL,
      MODE_RX_DRAIN,
      MODE_TX_FILL,
      MODE_TX_DRAIN,
      MODE_MIX
   } burst_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_func = FUNC_RX;
   logic [7:0] req_data = 8'd0;
   logic       req_overrun_flag = 1'b0;
   logic       req_framing_flag = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_read_valid;
   logic [7:0] rsp_read_byte;
   logic       rsp_write_accepted;
   logic       rsp_send_valid;
   logic [7:0] rsp_send_byte;
   logic [6:0] rsp_rx_queued;
   logic       rsp_tx_pending;
   logic       rsp_tx_empty;
   logic [7:0] rsp_dropped_count;
   logic [7:0] rsp_overrun_count;
   logic [7:0] rsp_framing_count;
   logic [6:0] rsp_max_queued;
   logic       csr_write_enable = 1'b0;
   logic [1:0] csr_index = CSR_FLOW_ENABLE;
   logic [6:0] csr_wdata = 7'd0;

   ufx_ring_shadow shadow;
   int             req_gap_max = GAP_MAX;
   int             rsp_gap_max = GAP_MAX;
   int             cycles = 0;
   int             settings = 0;

   uart_fifo_xon_xoff dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_data           (req_data),
      .req_overrun_flag   (req_overrun_flag),
      .req_framing_flag   (req_framing_flag),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_valid     (rsp_read_valid),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_write_accepted (rsp_write_accepted),
      .rsp_send_valid     (rsp_send_valid),
      .rsp_send_byte      (rsp_send_byte),
      .rsp_rx_queued      (rsp_rx_queued),
      .rsp_tx_pending     (rsp_tx_pending),
      .rsp_tx_empty       (rsp_tx_empty),
      .rsp_dropped_count  (rsp_dropped_count),
      .rsp_overrun_count  (rsp_overrun_count),
      .rsp_framing_count  (rsp_framing_count),
      .rsp_max_queued     (rsp_max_queued),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("uart_fifo_xon_xoff_tb: errors");
         $finish;
      end
   end

   // Offer one transfer after a random gap and hold it until it is taken.
   // Signals settle between edges, so the negative edge shows what the next rising edge sees.
   task automatic send_item(input logic [2:0] func, input logic [7:0] data,
                            input logic ovr, input logic frm);
      int gap;
      bit taken;
      gap = (req_gap_max == 0) ? 0 : $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_data         <= data;
      req_overrun_flag <= ovr;
      req_framing_flag <= frm;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      shadow.apply_event(func, data, ovr, frm);
   endtask

   // Stop offering transfers and let every owed status arrive.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= val;
      @(posedge clock);
      shadow.set_reg(idx, val);
   endtask

   // Reprogram all three registers once the block has gone idle.
   task automatic program_regs(input logic flow_en, input logic [6:0] xoff,
                               input logic [6:0] xon);
      logic [6:0] flow_word;
      wait_idle();
      // Only bit 0 of the enable register matters; the upper bits are noise.
      flow_word = 7'($urandom_range(0, 127));
      flow_word[0] = flow_en;
      write_reg(CSR_FLOW_ENABLE, flow_word);
      write_reg(CSR_XOFF_LEVEL, xoff);
      write_reg(CSR_XON_LEVEL, xon);
      csr_write_enable <= 1'b0;
      settings++;
   endtask

   // Directed transfers: empty rings, data and flag extremes, and the flow handshake.
   task automatic run_directed();
      send_item(FUNC_READ, 8'h00, 1'b0, 1'b0);
      send_item(FUNC_TX_READY, 8'h00, 1'b0, 1'b0);
      send_item(FUNC_RX, 8'h00, 1'b1, 1'b0);
      send_item(FUNC_RX, 8'hFF, 1'b0, 1'b1);
      send_item(FUNC_RX, 8'hA5, 1'b1, 1'b1);
      send_item(FUNC_PEEK, 8'h00, 1'b0, 1'b0);
      send_item(FUNC_READ, 8'h00, 1'b0, 1'b0);
      send_item(FUNC_WRITE, 8'hFF, 1'b0, 1'b0);
      send_item(FUNC_TX_READY, 8'h00, 1'b0, 1'b0);
      send_item(FUNC_NOP_6, 8'hFF, 1'b1, 1'b1);
      send_item(FUNC_FLUSH, 8'h00, 1'b0, 1'b0);
      // Low levels: XOFF once, XON pending after draining, and sent before queued data.
      program_regs(1'b1, 7'd2, 7'd1);
      send_item(FUNC_RX, 8'h11, 1'b0, 1'b0);
      send_item(FUNC_RX, 8'h22, 1'b0, 1'b0);
      send_item(FUNC_RX, 8'h33, 1'b0, 1'b0);
      send_item(FUNC_READ, 8'h00, 1'b0, 1'b0);
      send_item(FUNC_READ, 8'h00, 1'b0, 1'b0);
      send_item(FUNC_READ, 8'h00, 1'b0, 1'b0);
      send_item(FUNC_WRITE, 8'h5A, 1'b0, 1'b0);
      send_item(FUNC_TX_READY, 8'h00, 1'b0, 1'b0);
      send_item(FUNC_TX_READY, 8'h00, 1'b0, 1'b0);
      send_item(FUNC_RX, 8'h44, 1'b0, 1'b0);
      send_item(FUNC_RX, 8'h55, 1'b0, 1'b0);
      send_item(FUNC_FLUSH, 8'h00, 1'b0, 1'b0);
      // A pending XON still goes out after flow control is switched off.
      program_regs(1'b0, 7'd2, 7'd1);
      send_item(FUNC_TX_READY, 8'h00, 1'b0, 1'b0);
      send_item(FUNC_RX, 8'h66, 1'b0, 1'b0);
      send_item(FUNC_RX, 8'h77, 1'b0, 1'b0);
      send_item(FUNC_FLUSH, 8'h00, 1'b0, 1'b0);
   endtask

   function automatic logic [2:0] pick_func(burst_mode_type mode);
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_RX_FILL:
            return (roll < 85) ? FUNC_RX : 3'($urandom_range(FUNC_READ, FUNC_TX_READY));
         MODE_RX_DRAIN: begin
            if (roll < 60) return FUNC_READ;
            if (roll < 72) return FUNC_PEEK;
            if (roll < 75) return FUNC_FLUSH;
            if (roll < 90) return FUNC_RX;
            return FUNC_TX_READY;
         end
         MODE_TX_FILL: begin
            if (roll < 75) return FUNC_WRITE;
            if (roll < 90) return FUNC_TX_READY;
            return FUNC_RX;
         end
         MODE_TX_DRAIN: begin
            if (roll < 70) return FUNC_TX_READY;
            if (roll < 85) return FUNC_WRITE;
            return FUNC_READ;
         end
         default: begin
            if (roll < 5) return FUNC_NOP_6;
            if (roll < 10) return FUNC_NOP_7;
            return 3'($urandom_range(FUNC_RX, FUNC_TX_READY));
         end
      endcase
   endfunction

   // Result side: random stall after each transfer, sampled between edges.
   initial begin : status_sink
      int      hold;
      rsp_type seen;
      hold = 0;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            seen.read_valid     = rsp_read_valid;
            seen.read_byte      = rsp_read_byte;
            seen.write_accepted = rsp_write_accepted;
            seen.send_valid     = rsp_send_valid;
            seen.send_byte      = rsp_send_byte;
            seen.rx_queued      = rsp_rx_queued;
            seen.tx_pending     = rsp_tx_pending;
            seen.tx_empty       = rsp_tx_empty;
            seen.dropped_count  = rsp_dropped_count;
            seen.overrun_count  = rsp_overrun_count;
            seen.framing_count  = rsp_framing_count;
            seen.max_queued     = rsp_max_queued;
            shadow.match_status(seen);
            hold = (rsp_gap_max == 0) ? 0 : $urandom_range(0, rsp_gap_max);
         end
         @(posedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold = hold - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Main sequence: reset, directed checks, then random phases under several settings.
   initial begin : stimulus
      int             done;
      int             burst;
      burst_mode_type mode;
      logic [2:0]     func;
      shadow = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: program_regs(1'b1, 7'd16, 7'd12);
            1: program_regs(1'b1, 7'd1, 7'd0);
            2: program_regs(1'b1, 7'd127, 7'd127);
            3: program_regs(1'b0, 7'($urandom_range(1, 127)), 7'($urandom_range(0, 127)));
            4: program_regs(1'b1, 7'($urandom_range(1, 127)), 7'($urandom_range(0, 127)));
            default: program_regs(1'b1, 7'd40, 7'd8);
         endcase
         done = 0;
         while (done < PHASE_ITEMS) begin
            mode  = burst_mode_type'($urandom_range(MODE_RX_FILL, MODE_MIX));
            burst = (mode == MODE_RX_FILL) ? $urandom_range(20, 160) : $urandom_range(8, 80);
            // Some bursts run with no idling on one side or both.
            req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            // A burst stops early once the phase has its share of transfers.
            for (int k = 0; k < burst && done < PHASE_ITEMS; k++) begin
               func = pick_func(mode);
               send_item(func, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
               if (func != FUNC_NOP_6 && func != FUNC_NOP_7) begin
                  done++;
               end
            end
         end
      end
      wait_idle();
      $display("Ran %0d transfers and checked %0d status words across %0d register settings.",
               shadow.events, shadow.checked, settings);
      $display("Saw %0d XOFF and %0d XON sends, %0d refused writes, final drop count %0d.",
               shadow.xoff_sent, shadow.xon_sent, shadow.refused, shadow.drops);
      if (shadow.errors == 0) begin
         $display("uart_fifo_xon_xoff_tb: clean");
      end else begin
         $display("uart_fifo_xon_xoff_tb: errors");
      end
      $finish;
   end

endmodule
